// ===== rtl/humidity_sensor_frame_decoder_unit_assert.svh =====
// Assertion macros shared by the checker of the frame decoder.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_UNIT_ASSERT_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HSFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hsfd_pkg.sv =====
// Package of the humidity sensor frame decoder: widths, frame record, CRC-8 step.
// No dependencies; every other file of the block but the assertion header imports it.
`timescale 1ns / 1ps

package hsfd_pkg;

    localparam int WORD_BYTES  = 2;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = WORD_BYTES * BYTE_W;
    localparam int CRC_POS     = WORD_BYTES;
    localparam int FRAME_BYTES = 2 * (WORD_BYTES + 1);
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int TEMP_W      = 15;
    localparam int HUM_W       = 14;
    localparam int SERIAL_W    = 2 * WORD_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [POS_W-1:0] POS_CRC1 = POS_W'(CRC_POS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_END  = POS_W'(FRAME_BYTES - 1);

    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

    localparam logic REG_FRAME_KIND = 1'b0;
    localparam logic KIND_MEASURE   = 1'b0;
    localparam logic KIND_SERIAL    = 1'b1;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic  kind;
        t_word word1;
        t_word word2;
        logic  good1;
        logic  good2;
    } t_frame;

    function automatic t_byte crc8_step(input t_byte crc, input t_byte data);
        t_byte c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/hsfd_if.sv =====
// Channel interfaces of the frame decoder: byte input and decoded result output.
// Depends on hsfd_pkg.
`timescale 1ns / 1ps

interface hsfd_in_if;
    import hsfd_pkg::*;
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  frame_start;
    modport source (output valid, data_byte, frame_start, input ready);
    modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface hsfd_out_if;
    import hsfd_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [TEMP_W-1:0]   temperature_centi;
    logic        [HUM_W-1:0]    humidity_centi;
    logic        [SERIAL_W-1:0] serial_number;
    logic                       first_crc_ok;
    logic                       second_crc_ok;
    modport source (output valid, temperature_centi, humidity_centi, serial_number,
                    first_crc_ok, second_crc_ok, input ready);
    modport sink   (input valid, temperature_centi, humidity_centi, serial_number,
                    first_crc_ok, second_crc_ok, output ready);
endinterface

// ===== rtl/hsfd_queue.sv =====
// Short frame queue between the byte front end and the conversion pipeline.
// Depends on hsfd_pkg.
`timescale 1ns / 1ps

module hsfd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hsfd_pkg::t_frame i_frame,
    output logic            o_not_full,
    output logic            o_valid,
    input  logic            i_pop,
    output hsfd_pkg::t_frame o_frame
);
    import hsfd_pkg::*;

    t_frame              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW-1:0] n_wr;
    logic [QUEUE_AW-1:0] n_rd;
    logic [QUEUE_AW:0]   n_count;
    logic                do_push;
    logic                do_pop;

    assign o_not_full = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_frame    = r_mem[r_rd];
    assign do_push    = i_push && o_not_full;
    assign do_pop     = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

endmodule

// ===== rtl/hsfd_front.sv =====
// Front end: takes response bytes, tracks frame position, runs the CRC-8 checks
// and assembles both words. Depends on hsfd_pkg and hsfd_in_if.
`timescale 1ns / 1ps

module hsfd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hsfd_in_if.sink          i_in,
    input  logic             i_frame_kind,
    input  logic             i_queue_ready,
    output logic             o_push,
    output hsfd_pkg::t_frame o_frame
);
    import hsfd_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    t_byte            r_crc;
    t_byte            n_crc;
    t_word            r_word1;
    t_word            n_word1;
    t_word            r_word2;
    t_word            n_word2;
    logic             r_good1;
    logic             n_good1;
    logic             accept;
    logic             restart;
    logic [POS_W-1:0] pos;
    t_byte            crc;

    assign i_in.ready = i_queue_ready;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        restart = i_in.frame_start || (r_pos > POS_END);
        pos     = restart ? '0 : r_pos;
        crc     = restart ? CRC_INIT : r_crc;
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_word1 = r_word1;
        n_word2 = r_word2;
        n_good1 = r_good1;
        if (accept) begin
            priority if (pos < POS_CRC1) begin
                n_crc   = crc8_step(crc, i_in.data_byte);
                n_word1 = {r_word1[WORD_W-BYTE_W-1:0], i_in.data_byte};
                n_pos   = pos + 1'b1;
            end else if (pos == POS_CRC1) begin
                n_good1 = (crc == i_in.data_byte);
                n_crc   = CRC_INIT;
                n_pos   = pos + 1'b1;
            end else if (pos < POS_LAST) begin
                n_crc   = crc8_step(crc, i_in.data_byte);
                n_word2 = {r_word2[WORD_W-BYTE_W-1:0], i_in.data_byte};
                n_pos   = pos + 1'b1;
            end else begin
                n_crc   = CRC_INIT;
                n_pos   = '0;
            end
        end
    end

    assign o_push        = accept && (pos == POS_LAST);
    assign o_frame.kind  = i_frame_kind;
    assign o_frame.word1 = r_word1;
    assign o_frame.word2 = r_word2;
    assign o_frame.good1 = r_good1;
    assign o_frame.good2 = (crc == i_in.data_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_crc   <= CRC_INIT;
            r_word1 <= '0;
            r_word2 <= '0;
            r_good1 <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_word1 <= n_word1;
            r_word2 <= n_word2;
            r_good1 <= n_good1;
        end
    end

endmodule

// ===== rtl/hsfd_back.sv =====
// Back end: three-stage elastic pipeline that scales both words and divides by
// 65535 with rounding, ending in the output register. Depends on hsfd_pkg, hsfd_out_if.
`timescale 1ns / 1ps

module hsfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_frame_valid,
    input  hsfd_pkg::t_frame i_frame,
    output logic             o_frame_pop,
    hsfd_out_if.source       o_out
);
    import hsfd_pkg::*;

    localparam int PROD_W = 31;
    localparam int EST_W  = PROD_W + 1;
    localparam int QUO_W  = WORD_W;

    localparam logic [PROD_W-1:0] TEMP_SPAN  = PROD_W'(17500);
    localparam logic [PROD_W-1:0] HUM_SPAN   = PROD_W'(10000);
    localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(32767);
    localparam logic [EST_W-1:0]  DIVISOR    = EST_W'(65535);
    localparam logic [TEMP_W-1:0] TEMP_BASE  = TEMP_W'(4500);

    function automatic logic [QUO_W-1:0] quo_estimate(input logic [PROD_W-1:0] x);
        logic [EST_W-1:0] s;
        s = EST_W'(x) + EST_W'(x >> WORD_W);
        return QUO_W'(s >> WORD_W);
    endfunction

    function automatic logic [QUO_W-1:0] quo_fix(input logic [PROD_W-1:0] x,
                                                 input logic [QUO_W-1:0]  q);
        logic [EST_W-1:0] qm;
        logic [EST_W-1:0] r;
        qm = {q, {WORD_W{1'b0}}} - EST_W'(q);
        r  = EST_W'(x) - qm;
        return (r >= DIVISOR) ? q + 1'b1 : q;
    endfunction

    logic              r_va;
    logic              r_vb;
    logic              r_vc;
    t_frame            r_fa;
    t_frame            r_fb;
    logic [PROD_W-1:0] r_xt_a;
    logic [PROD_W-1:0] r_xh_a;
    logic [PROD_W-1:0] r_xt_b;
    logic [PROD_W-1:0] r_xh_b;
    logic [QUO_W-1:0]  r_qt_b;
    logic [QUO_W-1:0]  r_qh_b;
    logic signed [TEMP_W-1:0] r_temp;
    logic [HUM_W-1:0]    r_hum;
    logic [SERIAL_W-1:0] r_serial;
    logic                r_ok1;
    logic                r_ok2;
    logic              out_free;
    logic              b_free;
    logic              a_free;
    logic [QUO_W-1:0]  qt_fix;
    logic [QUO_W-1:0]  qh_fix;

    assign out_free    = !r_vc || o_out.ready;
    assign b_free      = !r_vb || out_free;
    assign a_free      = !r_va || b_free;
    assign o_frame_pop = i_frame_valid && a_free;

    assign qt_fix = quo_fix(r_xt_b, r_qt_b);
    assign qh_fix = quo_fix(r_xh_b, r_qh_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (a_free) begin
                r_va <= o_frame_pop;
            end
            if (b_free) begin
                r_vb <= r_va;
            end
            if (out_free) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_frame_pop) begin
            r_fa   <= i_frame;
            r_xt_a <= PROD_W'(i_frame.word1) * TEMP_SPAN + ROUND_BIAS;
            r_xh_a <= PROD_W'(i_frame.word2) * HUM_SPAN + ROUND_BIAS;
        end
        if (b_free && r_va) begin
            r_fb   <= r_fa;
            r_xt_b <= r_xt_a;
            r_xh_b <= r_xh_a;
            r_qt_b <= quo_estimate(r_xt_a);
            r_qh_b <= quo_estimate(r_xh_a);
        end
        if (out_free && r_vb) begin
            r_ok1 <= r_fb.good1;
            r_ok2 <= r_fb.good2;
            if (r_fb.kind == KIND_SERIAL) begin
                r_temp   <= '0;
                r_hum    <= '0;
                r_serial <= {r_fb.word1, r_fb.word2};
            end else begin
                r_temp   <= $signed(TEMP_W'(qt_fix) - TEMP_BASE);
                r_hum    <= HUM_W'(qh_fix);
                r_serial <= '0;
            end
        end
    end

    assign o_out.valid             = r_vc;
    assign o_out.temperature_centi = r_temp;
    assign o_out.humidity_centi    = r_hum;
    assign o_out.serial_number     = r_serial;
    assign o_out.first_crc_ok      = r_ok1;
    assign o_out.second_crc_ok     = r_ok2;

endmodule

// ===== rtl/humidity_sensor_frame_decoder_unit.sv =====
// Top level of the humidity sensor frame decoder: configuration register, front
// end, frame queue and conversion pipeline. Depends on hsfd_pkg, hsfd_if, submodules.
//
// Usage:
// Response bytes enter on i_in (valid/ready); frame_start marks the first byte of a
// six-byte frame, and frames may also follow each other without marks. After the
// sixth byte one result word leaves on o_out with both CRC flags and either the
// converted temperature and humidity or the serial number, as selected by the
// frame_kind register at APB address 0. Throughput is one byte per cycle while
// the queue has room. After the sixth byte is accepted the frame is written into
// the queue, has its scaling multiplies registered as it leaves, then passes
// through the divide-by-65535 estimate register and its correction step into the
// output register.
// When o_out is stalled the pipeline and the two-entry frame queue fill up;
// i_in.ready drops only when the queue is full.
// Reset clears the frame position, the queue and the pipeline valids, sets the CRC
// to 0xFF and sets frame_kind to measurement mode.
`timescale 1ns / 1ps

module humidity_sensor_frame_decoder_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    hsfd_in_if.sink                          i_in,
    hsfd_out_if.source                       o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hsfd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [hsfd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [hsfd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import hsfd_pkg::*;

    logic   r_frame_kind;
    logic   cfg_write;
    logic   reg_sel;
    logic   push;
    logic   queue_not_full;
    logic   queue_valid;
    logic   queue_pop;
    t_frame push_frame;
    t_frame pop_frame;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[APB_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_sel == REG_FRAME_KIND) ?
                       {{(APB_DATA_W-1){1'b0}}, r_frame_kind} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_kind <= KIND_MEASURE;
        end else if (cfg_write && (reg_sel == REG_FRAME_KIND)) begin
            r_frame_kind <= pwdata[0];
        end
    end

    hsfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_frame_kind  (r_frame_kind),
        .i_queue_ready (queue_not_full),
        .o_push        (push),
        .o_frame       (push_frame)
    );

    hsfd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_frame    (push_frame),
        .o_not_full (queue_not_full),
        .o_valid    (queue_valid),
        .i_pop      (queue_pop),
        .o_frame    (pop_frame)
    );

    hsfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (queue_valid),
        .i_frame       (pop_frame),
        .o_frame_pop   (queue_pop),
        .o_out         (o_out)
    );

endmodule

// ===== rtl/hsfd_checker.sv =====
// Port-level checker of the frame decoder, bound to the top level.
// Depends on hsfd_pkg and humidity_sensor_frame_decoder_unit_assert.svh.
`timescale 1ns / 1ps
`include "humidity_sensor_frame_decoder_unit_assert.svh"

module hsfd_checker (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    i_out_valid,
    input logic                                    i_out_ready,
    input logic signed [hsfd_pkg::TEMP_W-1:0]      i_temperature_centi,
    input logic        [hsfd_pkg::HUM_W-1:0]       i_humidity_centi,
    input logic        [hsfd_pkg::SERIAL_W-1:0]    i_serial_number
);
    import hsfd_pkg::*;

    `HSFD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_temperature_centi) && $stable(i_humidity_centi)
        && $stable(i_serial_number), "stalled result changed")
    `HSFD_ASSERT_SAME(a_mode_exclusive, i_out_valid,
        (i_serial_number == '0) || ((i_temperature_centi == '0) && (i_humidity_centi == '0)),
        "result mixes serial number and measurement")
    `HSFD_ASSERT_SAME(a_range, i_out_valid,
        (i_temperature_centi >= -15'sd4500) && (i_humidity_centi <= 14'd10000),
        "converted value out of range")
    `HSFD_ASSERT_SAME(a_reset_empty, $rose(i_rst_n), !i_out_valid,
        "result present right after reset")

endmodule

bind humidity_sensor_frame_decoder_unit hsfd_checker u_hsfd_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_temperature_centi (o_out.temperature_centi),
    .i_humidity_centi    (o_out.humidity_centi),
    .i_serial_number     (o_out.serial_number)
);
